>>> sv/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, pattern tables and the window classifier of the HTML entity
// decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int PAT_COUNT = 8;
    localparam int WIN_DEPTH = 7;

    typedef logic [WIN_DEPTH-1:0][7:0] win_t;
    typedef logic [2:0]                wlen_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic       match;
        logic       prefix;
        logic [7:0] repl;
    } class_t;

    localparam logic [7:0] PAT_TEXT [PAT_COUNT][WIN_DEPTH] = '{
        '{"&", "q", "u", "o", "t", ";", 8'h00},
        '{"&", "a", "p", "o", "s", ";", 8'h00},
        '{"&", "#", "3", "9", ";", 8'h00, 8'h00},
        '{"&", "a", "m", "p", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00, 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00, 8'h00},
        '{"&", "f", "r", "a", "s", "l", ";"},
        '{"<", "b", "r", ">", 8'h00, 8'h00, 8'h00}
    };

    localparam wlen_t PAT_LEN [PAT_COUNT] = '{
        3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd7, 3'd4
    };

    localparam logic [7:0] PAT_REPL [PAT_COUNT] = '{
        8'h22, 8'h27, 8'h27, 8'h26, 8'h3E, 8'h3C, 8'h2F, 8'h0A
    };

    // Full match or proper prefix of any pattern for the first len bytes.
    function automatic class_t classify(win_t w, wlen_t len);
        class_t r;
        logic   hit;
        r = '0;
        for (int p = 0; p < PAT_COUNT; p++)
        begin
            hit = (len != 3'd0) && (len <= PAT_LEN[p]);
            for (int j = 0; j < WIN_DEPTH; j++)
            begin
                if ((3'(j) < len) && (w[j] != PAT_TEXT[p][j]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                if (len == PAT_LEN[p])
                begin
                    r.match = 1'b1;
                    r.repl  = PAT_REPL[p];
                end
                else
                begin
                    r.prefix = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> sv/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Input side: takes text words and holds them in a four-entry queue for the
// match engine.
// ----------------------------------------------------------------------------
module hed_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output logic           pop_valid,
    input  logic           pop_ready,
    output hed_pkg::item_t pop_item
);
    import hed_pkg::*;

    item_t      mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 3'd4);
    assign pop_valid = (count_reg != 3'd0);
    assign pop_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{data: in_byte, last: in_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Match engine: keeps the pending window, emits at most one output word per
// cycle while the output is not stalled (literal or replacement) and appends
// the next queued word when the current one is finished.
// ----------------------------------------------------------------------------
module hed_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  hed_pkg::item_t pop_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           text_end
);
    import hed_pkg::*;

    win_t       win_reg;
    win_t       win_next;
    wlen_t      len_reg;
    wlen_t      len_next;
    logic       busy_reg;
    logic       busy_next;
    logic       last_reg;
    logic       last_next;
    logic       flush_reg;
    logic       flush_next;
    logic       ov_reg;
    logic       ov_next;
    logic [7:0] ob_reg;
    logic       orl_reg;
    logic       ote_reg;

    class_t     c0;
    class_t     c1;
    win_t       win_shift;
    win_t       post_win;
    wlen_t      post_len;
    logic       post_flush;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_rl;
    logic       done;
    logic       stall;

    assign win_shift = win_reg >> 8;
    assign c0        = classify(win_reg, len_reg);
    assign c1        = classify(win_shift, len_reg - 3'd1);

    always_comb
    begin
        post_win   = win_reg;
        post_len   = len_reg;
        post_flush = flush_reg;
        emit       = 1'b0;
        emit_byte  = win_reg[0];
        emit_rl    = 1'b0;
        done       = 1'b1;
        if (busy_reg)
        begin
            priority if (flush_reg)
            begin
                emit     = 1'b1;
                emit_rl  = (len_reg == 3'd1);
                post_win = win_shift;
                post_len = len_reg - 3'd1;
            end
            else if (c0.match)
            begin
                emit      = 1'b1;
                emit_byte = c0.repl;
                emit_rl   = 1'b1;
                post_len  = 3'd0;
            end
            else if (c0.prefix && !last_reg)
            begin
                emit = 1'b0;
            end
            else if (c0.prefix)
            begin
                emit       = 1'b1;
                emit_rl    = (len_reg == 3'd1);
                post_flush = 1'b1;
                post_win   = win_shift;
                post_len   = len_reg - 3'd1;
            end
            else
            begin
                emit     = 1'b1;
                emit_rl  = (len_reg == 3'd1) || (!last_reg && c1.prefix && !c1.match);
                post_win = win_shift;
                post_len = len_reg - 3'd1;
            end
            done = !emit || emit_rl;
        end
    end

    assign stall     = emit && ov_reg && !out_ready;
    assign pop_ready = !stall && done;

    always_comb
    begin
        win_next   = win_reg;
        len_next   = len_reg;
        busy_next  = busy_reg;
        last_next  = last_reg;
        flush_next = flush_reg;
        ov_next    = ov_reg && !out_ready;
        if (!stall)
        begin
            if (emit)
            begin
                ov_next = 1'b1;
            end
            win_next   = post_win;
            len_next   = post_len;
            flush_next = post_flush;
            if (done)
            begin
                busy_next  = 1'b0;
                flush_next = 1'b0;
                if (pop_valid)
                begin
                    for (int j = 0; j < WIN_DEPTH; j++)
                    begin
                        if (3'(j) == post_len)
                        begin
                            win_next[j] = pop_item.data;
                        end
                    end
                    len_next  = post_len + 3'd1;
                    busy_next = 1'b1;
                    last_next = pop_item.last;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (!stall && emit)
        begin
            ob_reg  <= emit_byte;
            orl_reg <= emit_rl;
            ote_reg <= emit_rl && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            busy_reg  <= 1'b0;
            last_reg  <= 1'b0;
            flush_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            busy_reg  <= busy_next;
            last_reg  <= last_next;
            flush_reg <= flush_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign run_last  = orl_reg;
    assign text_end  = ote_reg;

endmodule

>>> sv/html_entity_decoder_unit.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_unit
// Streaming HTML entity decoder: one text byte per input word, literal bytes
// and entity replacements out.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_ready  in_byte, in_last
//   out      out  out_valid/out_ready  out_byte, run_last, text_end
//
// The input queue takes new words while the match engine still works on
// earlier ones; the engine emits one output word at a time, so an input that
// releases k bytes occupies it until all k are out.
// A four-word input queue absorbs bursts; the output is one register deep.
// Reset empties the queue and the pending window. Either side may stall.
// ----------------------------------------------------------------------------
module html_entity_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);
    import hed_pkg::*;

    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    hed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    hed_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule
